FILE: rtl/tnb64_pkg.sv
// Package for the base64 tensor notation parser: character codes, event and error codes,
// and the structs passed between the classifier, the parser core and the top level.
// It has no dependencies.
package tnb64_pkg;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CHAR_OPEN      = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE     = 8'h7D;

    localparam logic [3:0] EV_NONE        = 4'd0;
    localparam logic [3:0] EV_NAME_CHAR   = 4'd1;
    localparam logic [3:0] EV_NAME_END    = 4'd2;
    localparam logic [3:0] EV_DIMS_BYTES  = 4'd3;
    localparam logic [3:0] EV_DIMS_END    = 4'd4;
    localparam logic [3:0] EV_VALUE_BYTES = 4'd5;
    localparam logic [3:0] EV_TENSOR_END  = 4'd6;
    localparam logic [3:0] EV_SUCCESS     = 4'd7;
    localparam logic [3:0] EV_ERROR       = 4'd8;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_LENGTH     = 2'd2;
    localparam logic [1:0] ERR_PADDING    = 2'd3;

    localparam logic [15:0] REPORT_MAX    = 16'hFFFF;

    typedef struct packed {
        logic       is_ws;
        logic       is_b64;
        logic       is_pad;
        logic [5:0] sextet;
    } char_class_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [7:0]  name_char;
        logic [7:0]  byte_zero;
        logic [7:0]  byte_one;
        logic [7:0]  byte_two;
        logic [1:0]  byte_count;
        logic [1:0]  fault_code;
        logic [15:0] line_number;
        logic [15:0] column_number;
    } result_t;

endpackage

FILE: rtl/tnb64_char_class.sv
// Character classifier: whitespace test and base64 digit decode for one character.
// Depends on tnb64_pkg.
module tnb64_char_class (
    input  logic [7:0]             char_byte,
    output tnb64_pkg::char_class_t cls
);
    import tnb64_pkg::*;

    always_comb begin
        cls.is_ws  = (char_byte == CHAR_SPACE) || (char_byte == CHAR_TAB) ||
                     (char_byte == CHAR_CR) || (char_byte == CHAR_LF);
        cls.is_pad = (char_byte == CHAR_EQUALS);
        cls.is_b64 = 1'b1;
        cls.sextet = 6'd0;
        if (char_byte >= CHAR_UPPER_A && char_byte <= CHAR_UPPER_Z) begin
            cls.sextet = 6'(char_byte - CHAR_UPPER_A);
        end else if (char_byte >= CHAR_LOWER_A && char_byte <= CHAR_LOWER_Z) begin
            cls.sextet = 6'(char_byte - CHAR_LOWER_A + 8'd26);
        end else if (char_byte >= CHAR_DIGIT_0 && char_byte <= CHAR_DIGIT_9) begin
            cls.sextet = 6'(char_byte - CHAR_DIGIT_0 + 8'd52);
        end else if (char_byte == CHAR_PLUS) begin
            cls.sextet = 6'd62;
        end else if (char_byte == CHAR_SLASH) begin
            cls.sextet = 6'd63;
        end else if (!cls.is_pad) begin
            cls.is_b64 = 1'b0;
        end
    end

endmodule

FILE: rtl/tnb64_parser.sv
// Parser core: phase state machine, base64 group assembly and position tracking.
// Depends on tnb64_pkg and tnb64_char_class.
module tnb64_parser #(
    parameter int POS_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           char_byte,
    input  logic                 start_req,
    output tnb64_pkg::result_t   result
);
    import tnb64_pkg::*;

    localparam logic [2:0] PH_OPEN         = 3'd0;
    localparam logic [2:0] PH_LIST         = 3'd1;
    localparam logic [2:0] PH_AFTER_TENSOR = 3'd2;
    localparam logic [2:0] PH_NAME         = 3'd3;
    localparam logic [2:0] PH_AFTER_NAME   = 3'd4;
    localparam logic [2:0] PH_AFTER_COLON  = 3'd5;
    localparam logic [2:0] PH_DIMS         = 3'd6;
    localparam logic [2:0] PH_VALUES       = 3'd7;

    localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    char_class_t cls;

    logic [2:0]           phase_reg, phase_next, phase_cur;
    logic                 esc_reg, esc_next, esc_cur;
    logic [1:0]           gpos_reg, gpos_next, gpos_cur;
    logic [17:0]          bits_reg, bits_next, bits_cur;
    logic [1:0]           pad_reg, pad_next, pad_cur;
    logic [POS_WIDTH-1:0] line_reg, line_next, line_cur;
    logic [POS_WIDTH-1:0] col_reg, col_next, col_cur;
    logic                 done_reg, done_next, done_cur;
    logic                 err_reg, err_next, err_cur;

    logic        fail_en;
    logic [1:0]  fail_code;
    logic        list_mode;
    logic        after_tensor;
    logic [5:0]  digit;
    logic [23:0] full;
    logic [31:0] line_wide;
    logic [31:0] col_wide;

    tnb64_char_class u_class (
        .char_byte (char_byte),
        .cls       (cls)
    );

    always_comb begin
        phase_cur = start_req ? PH_OPEN : phase_reg;
        esc_cur   = start_req ? 1'b0 : esc_reg;
        gpos_cur  = start_req ? 2'd0 : gpos_reg;
        bits_cur  = start_req ? 18'd0 : bits_reg;
        pad_cur   = start_req ? 2'd0 : pad_reg;
        line_cur  = start_req ? POS_ONE : line_reg;
        col_cur   = start_req ? POS_ONE : col_reg;
        done_cur  = start_req ? 1'b0 : done_reg;
        err_cur   = start_req ? 1'b0 : err_reg;
    end

    assign digit     = cls.is_pad ? 6'd0 : cls.sextet;
    assign full      = {bits_cur, digit};
    assign line_wide = 32'(line_cur);
    assign col_wide  = 32'(col_cur);

    always_comb begin
        phase_next   = phase_cur;
        esc_next     = esc_cur;
        gpos_next    = gpos_cur;
        bits_next    = bits_cur;
        pad_next     = pad_cur;
        line_next    = line_cur;
        col_next     = col_cur;
        done_next    = done_cur;
        err_next     = err_cur;
        result       = '0;
        fail_en      = 1'b0;
        fail_code    = ERR_NONE;
        list_mode    = 1'b0;
        after_tensor = 1'b0;

        if (!done_cur && !err_cur) begin
            unique case (phase_cur)
                PH_OPEN: begin
                    if (char_byte == CHAR_NUL && line_cur == POS_ONE && col_cur == POS_ONE) begin
                        done_next         = 1'b1;
                        result.event_kind = EV_SUCCESS;
                    end else if (char_byte == CHAR_OPEN) begin
                        phase_next = PH_LIST;
                    end else if (!cls.is_ws) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_UNEXPECTED;
                    end
                end
                PH_LIST: begin
                    list_mode = 1'b1;
                end
                PH_AFTER_TENSOR: begin
                    list_mode    = 1'b1;
                    after_tensor = 1'b1;
                end
                PH_NAME: begin
                    if (char_byte == CHAR_NUL) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_UNEXPECTED;
                    end else if (char_byte == CHAR_QUOTE && !esc_cur) begin
                        result.event_kind = EV_NAME_END;
                        phase_next        = PH_AFTER_NAME;
                    end else begin
                        result.event_kind = EV_NAME_CHAR;
                        result.name_char  = char_byte;
                        esc_next          = !esc_cur && (char_byte == CHAR_BACKSLASH);
                    end
                end
                PH_AFTER_NAME: begin
                    if (char_byte == CHAR_COLON) begin
                        phase_next = PH_AFTER_COLON;
                    end else if (!cls.is_ws) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_UNEXPECTED;
                    end
                end
                PH_AFTER_COLON: begin
                    if (char_byte == CHAR_QUOTE) begin
                        phase_next = PH_DIMS;
                        gpos_next  = 2'd0;
                        bits_next  = 18'd0;
                        pad_next   = 2'd0;
                    end else if (!cls.is_ws) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_UNEXPECTED;
                    end
                end
                PH_DIMS, PH_VALUES: begin
                    if (!cls.is_b64) begin
                        if (gpos_cur != 2'd0) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_LENGTH;
                        end else if (phase_cur == PH_DIMS && char_byte == CHAR_SEMICOLON) begin
                            result.event_kind = EV_DIMS_END;
                            phase_next        = PH_VALUES;
                            bits_next         = 18'd0;
                            pad_next          = 2'd0;
                        end else if (phase_cur == PH_VALUES && char_byte == CHAR_QUOTE) begin
                            result.event_kind = EV_TENSOR_END;
                            phase_next        = PH_AFTER_TENSOR;
                        end else begin
                            fail_en   = 1'b1;
                            fail_code = ERR_UNEXPECTED;
                        end
                    end else if (cls.is_pad && gpos_cur < 2'd2) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_PADDING;
                    end else if (!cls.is_pad && pad_cur != 2'd0) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_PADDING;
                    end else begin
                        if (cls.is_pad) begin
                            pad_next = pad_cur + 2'd1;
                        end
                        if (gpos_cur != 2'd3) begin
                            bits_next = {bits_cur[11:0], digit};
                            gpos_next = gpos_cur + 2'd1;
                        end else begin
                            // A completed group: the pad count sets how many bytes are real.
                            result.event_kind = (phase_cur == PH_DIMS) ? EV_DIMS_BYTES
                                                                       : EV_VALUE_BYTES;
                            result.byte_zero  = full[23:16];
                            result.byte_one   = (pad_next <= 2'd1) ? full[15:8] : 8'd0;
                            result.byte_two   = (pad_next == 2'd0) ? full[7:0] : 8'd0;
                            result.byte_count = 2'd3 - pad_next;
                            gpos_next         = 2'd0;
                            bits_next         = 18'd0;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (list_mode && !cls.is_ws) begin
                if (char_byte == CHAR_CLOSE) begin
                    done_next         = 1'b1;
                    result.event_kind = EV_SUCCESS;
                end else if (char_byte == CHAR_QUOTE) begin
                    phase_next = PH_NAME;
                    esc_next   = 1'b0;
                end else if (char_byte == CHAR_COMMA && after_tensor) begin
                    phase_next = PH_LIST;
                end else begin
                    fail_en   = 1'b1;
                    fail_code = ERR_UNEXPECTED;
                end
            end

            if (fail_en) begin
                err_next             = 1'b1;
                result.event_kind    = EV_ERROR;
                result.fault_code    = fail_code;
                result.line_number   = (line_wide > 32'(REPORT_MAX)) ? REPORT_MAX
                                                                     : line_wide[15:0];
                result.column_number = (col_wide > 32'(REPORT_MAX)) ? REPORT_MAX
                                                                    : col_wide[15:0];
            end

            if (char_byte == CHAR_LF) begin
                if (line_cur != POS_MAX) begin
                    line_next = line_cur + POS_ONE;
                end
                col_next = POS_ONE;
            end else if (col_cur != POS_MAX) begin
                col_next = col_cur + POS_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPEN;
            esc_reg   <= 1'b0;
            gpos_reg  <= 2'd0;
            bits_reg  <= 18'd0;
            pad_reg   <= 2'd0;
            line_reg  <= POS_ONE;
            col_reg   <= POS_ONE;
            done_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            gpos_reg  <= gpos_next;
            bits_reg  <= bits_next;
            pad_reg   <= pad_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: rtl/tensor_notation_base64_parser_unit.sv
// Top level of the base64 tensor notation parser: input register, parser core, result register.
// Depends on tnb64_pkg and tnb64_parser.
//
// One character enters per request and one result leaves for each, in order. A character sits
// in the input register, passes the parser's state update, and lands in the result register
// when the parser steps, so m_valid rises once the input register has handed its character to
// the result register. The sustained rate is one character per cycle while m_ready stays high.
// Each of the two registers holds one request, so one more character is still taken while a
// result waits for m_ready.
// After success (the closing brace, or NUL as the first character) or the first error every
// result reports no event until a request arrives with s_start_req set. Error line and column
// saturate at 2^POS_WIDTH-1 internally and are reported capped at 65535.
module tensor_notation_base64_parser_unit #(
    parameter int POS_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_start_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_kind,
    output logic [7:0]  m_name_char,
    output logic [7:0]  m_byte_zero,
    output logic [7:0]  m_byte_one,
    output logic [7:0]  m_byte_two,
    output logic [1:0]  m_byte_count,
    output logic [1:0]  m_fault_code,
    output logic [15:0] m_line_number,
    output logic [15:0] m_column_number
);
    import tnb64_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_start_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    step_result;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tnb64_parser #(
        .POS_WIDTH (POS_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .char_byte (in_char_reg),
        .start_req (in_start_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg  <= s_char_byte;
            in_start_reg <= s_start_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = out_reg.event_kind;
    assign m_name_char     = out_reg.name_char;
    assign m_byte_zero     = out_reg.byte_zero;
    assign m_byte_one      = out_reg.byte_one;
    assign m_byte_two      = out_reg.byte_two;
    assign m_byte_count    = out_reg.byte_count;
    assign m_fault_code    = out_reg.fault_code;
    assign m_line_number   = out_reg.line_number;
    assign m_column_number = out_reg.column_number;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_char_reg))
        else $error("Held input request changed before it was parsed.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == EV_ERROR |->
            m_fault_code != ERR_NONE && m_line_number != 16'd0 && m_column_number != 16'd0)
        else $error("Error result without code or position.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == EV_DIMS_BYTES || m_event_kind == EV_VALUE_BYTES) |->
            m_byte_count != 2'd0)
        else $error("Decoded group reports no bytes.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != EV_ERROR |->
            m_fault_code == ERR_NONE && m_line_number == 16'd0)
        else $error("Error fields set on a result that is not an error.");
`endif

endmodule
